// ===== rtl/tac_pkg.sv =====
package tac_pkg;

   // Command codes carried on the request channel.
   localparam logic CMD_EDGE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMER_PERIOD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_EDGE_GAP = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STALL_RPM    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_DUTY    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RPM_SCALE    = 3'd4;

   // Register values after reset.
   localparam logic [15:0] RESET_TIMER_PERIOD = 16'd62500;
   localparam logic [15:0] RESET_MIN_EDGE_GAP = 16'd62;
   localparam logic [15:0] RESET_STALL_RPM    = 16'd450;
   localparam logic [15:0] RESET_IDLE_DUTY    = 16'd900;
   localparam logic [7:0]  RESET_RPM_SCALE    = 8'd30;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   // Depth of the tick queue between the front and the back.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = 2;

   typedef struct packed {
      logic [15:0] timer_period;
      logic [15:0] min_edge_gap;
      logic [15:0] stall_rpm;
      logic [15:0] idle_duty;
      logic [7:0]  rpm_scale;
   } tac_cfg_type;

   // One tick as handed from the front to the back.
   typedef struct packed {
      logic [15:0] pulse_count;
      logic [15:0] requested_duty;
   } tac_tick_type;

endpackage

// ===== rtl/tac_queue.sv =====
module tac_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tac_pkg::tac_tick_type push_data,
   output logic                  full,
   input  logic                  pop,
   output tac_pkg::tac_tick_type pop_data,
   output logic                  empty
);
   import tac_pkg::*;

   tac_tick_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_W:0]     fill_ff;

   assign full     = (fill_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (fill_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   fill_ff <= fill_ff + 1'b1;
            2'b01:   fill_ff <= fill_ff - 1'b1;
            default: fill_ff <= fill_ff;
         endcase
      end
   end

endmodule

// ===== rtl/tac_front.sv =====
module tac_front (
   input  logic                  clock,
   input  logic                  reset,
   input  tac_pkg::tac_cfg_type  cfg,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_command,
   input  logic [15:0]           req_edge_time,
   input  logic                  req_pin_level,
   input  logic [15:0]           req_requested_duty,
   output logic                  push,
   output tac_pkg::tac_tick_type push_data,
   input  logic                  q_full
);
   import tac_pkg::*;

   logic [15:0] last_edge_ff, last_edge_in;
   logic [15:0] count_ff, count_in;
   logic [16:0] wrapped_sum;
   logic [16:0] gap;
   logic        accept;

   // Edges never wait; only a tick needs room in the queue.
   assign req_ready = (req_command == CMD_EDGE) || !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      wrapped_sum = {1'b0, req_edge_time} + {1'b0, cfg.timer_period};
      if (req_edge_time >= last_edge_ff) begin
         gap = {1'b0, req_edge_time - last_edge_ff};
      end else if (wrapped_sum > {1'b0, last_edge_ff}) begin
         gap = wrapped_sum - {1'b0, last_edge_ff};
      end else begin
         gap = '0;
      end

      last_edge_in = last_edge_ff;
      count_in     = count_ff;
      push         = 1'b0;
      push_data.pulse_count    = count_ff;
      push_data.requested_duty = req_requested_duty;

      if (accept) begin
         if (req_command == CMD_TICK) begin
            push     = 1'b1;
            count_in = '0;
         end else begin
            last_edge_in = req_edge_time;
            if (req_pin_level && (gap > {1'b0, cfg.min_edge_gap}) &&
                (count_ff != COUNT_MAX)) begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_edge_ff <= '0;
         count_ff     <= '0;
      end else begin
         last_edge_ff <= last_edge_in;
         count_ff     <= count_in;
      end
   end

endmodule

// ===== rtl/tac_back.sv =====
module tac_back #(
   parameter int unsigned AVG_DEPTH    = 3,
   parameter int unsigned RETRY_PHASES = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tac_pkg::tac_cfg_type  cfg,
   output logic                  pop,
   input  tac_pkg::tac_tick_type pop_data,
   input  logic                  q_empty,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [15:0]           rsp_rpm,
   output logic [15:0]           rsp_average_rpm,
   output logic                  rsp_stalled,
   output logic [15:0]           rsp_duty_override
);
   import tac_pkg::*;

   localparam int unsigned DEPTH_LOG   = $clog2(AVG_DEPTH);
   localparam int unsigned IDX_W       = (AVG_DEPTH > 1) ? DEPTH_LOG : 1;
   localparam int unsigned PHASE_W     = $clog2(RETRY_PHASES);
   localparam int unsigned SUM_W       = 16 + DEPTH_LOG;
   // Division by the ring depth is a multiply by a rounded-up reciprocal.
   localparam int unsigned RecipShift  = SUM_W + DEPTH_LOG;
   localparam int unsigned PROD_W      = SUM_W + RecipShift + 1;
   localparam logic [RecipShift:0] RECIP =
      (RecipShift+1)'(((64'd1 << RecipShift) + AVG_DEPTH - 1) / AVG_DEPTH);

   logic                  adv;

   logic                  s1_valid_ff;
   logic [23:0]           s1_product_ff;
   logic [15:0]           s1_duty_ff;

   logic                  s2_valid_ff;
   logic [15:0]           s2_speed_ff;
   logic                  s2_stalled_ff;
   logic [15:0]           s2_override_ff;
   logic [SUM_W-1:0]      s2_total_ff;

   logic                  s3_valid_ff;
   logic [15:0]           s3_speed_ff;
   logic                  s3_stalled_ff;
   logic [15:0]           s3_override_ff;
   logic [PROD_W-1:0]     s3_product_ff;

   logic                  out_valid_ff;
   logic [15:0]           out_rpm_ff;
   logic [15:0]           out_average_ff;
   logic                  out_stalled_ff;
   logic [15:0]           out_override_ff;

   logic [15:0]           ring_ff [AVG_DEPTH];
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [PHASE_W-1:0]    phase_ff, phase_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;

   logic [15:0]           speed;
   logic                  stall;
   logic [IDX_W-1:0]      next_idx;
   logic [SUM_W-1:0]      new_sum;
   logic [15:0]           override_in;
   logic [SUM_W-1:0]      total_in;
   logic                  ring_write;

   // The whole pipe moves together whenever the output slot can take a value.
   assign adv = !out_valid_ff || rsp_ready;
   assign pop = adv && !q_empty;

   always_comb begin
      speed    = (s1_product_ff > 24'h00FFFF) ? 16'hFFFF : s1_product_ff[15:0];
      stall    = (speed < cfg.stall_rpm) && (s1_duty_ff > cfg.idle_duty);
      next_idx = (idx_ff == IDX_W'(AVG_DEPTH - 1)) ? '0 : idx_ff + 1'b1;
      new_sum  = sum_ff - SUM_W'(ring_ff[next_idx]) + SUM_W'(speed);

      idx_in      = idx_ff;
      phase_in    = phase_ff;
      sum_in      = sum_ff;
      ring_write  = 1'b0;
      override_in = '0;
      total_in    = new_sum;

      if (stall) begin
         override_in = (phase_ff == '0) ? cfg.idle_duty : s1_duty_ff;
         phase_in    = (phase_ff == PHASE_W'(RETRY_PHASES - 1)) ? '0 : phase_ff + 1'b1;
         total_in    = sum_ff;
      end else begin
         phase_in   = PHASE_W'(1);
         idx_in     = next_idx;
         sum_in     = new_sum;
         ring_write = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         phase_ff <= '0;
         sum_ff   <= '0;
         for (int k = 0; k < AVG_DEPTH; k++) begin
            ring_ff[k] <= '0;
         end
      end else if (adv && s1_valid_ff) begin
         idx_ff   <= idx_in;
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         if (ring_write) begin
            ring_ff[next_idx] <= speed;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= !q_empty;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_product_ff   <= 24'(pop_data.pulse_count) * 24'(cfg.rpm_scale);
         s1_duty_ff      <= pop_data.requested_duty;

         s2_speed_ff     <= speed;
         s2_stalled_ff   <= stall;
         s2_override_ff  <= override_in;
         s2_total_ff     <= total_in;

         s3_speed_ff     <= s2_speed_ff;
         s3_stalled_ff   <= s2_stalled_ff;
         s3_override_ff  <= s2_override_ff;
         s3_product_ff   <= PROD_W'(s2_total_ff) * PROD_W'(RECIP);

         out_rpm_ff      <= s3_speed_ff;
         out_stalled_ff  <= s3_stalled_ff;
         out_override_ff <= s3_override_ff;
         out_average_ff  <= s3_product_ff[RecipShift +: 16];
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_rpm           = out_rpm_ff;
   assign rsp_average_rpm   = out_average_ff;
   assign rsp_stalled       = out_stalled_ff;
   assign rsp_duty_override = out_override_ff;

endmodule

// ===== rtl/tachometer_with_stall_retry.sv =====
// Motor tachometer with a stall retry path.
// The request channel carries two kinds of transaction. A pin edge transaction
// (command 0) gives the timer value at the edge and the pin level after it; it
// never produces a response. A one-second tick transaction (command 1) gives the
// operator's requested duty and produces exactly one response transaction with
// the rpm, the running average, the stall flag and the duty override.
// The configuration channel writes one register per transaction by index and
// is always ready; it is meant to be used while no tick is in flight.
// Edge transactions are taken every cycle. A tick is taken in any cycle in
// which the four-entry tick queue has room, so one transaction per cycle is
// sustained while the receiver accepts responses. A tick's response passes
// through the queue, then the rpm multiply, the ring update, the reciprocal
// multiply for the average, and the output register.
// When the receiver stalls, the back pipeline holds, the queue fills and then
// further ticks wait, while edges keep being counted.
// Synchronous reset restores the register defaults and clears the pulse count,
// the speed ring, the ring sum and the retry phase.
module tachometer_with_stall_retry #(
   parameter int unsigned AVG_DEPTH    = 3,
   parameter int unsigned RETRY_PHASES = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_command,
   input  logic [15:0]                     req_edge_time,
   input  logic                            req_pin_level,
   input  logic [15:0]                     req_requested_duty,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [15:0]                     rsp_rpm,
   output logic [15:0]                     rsp_average_rpm,
   output logic                            rsp_stalled,
   output logic [15:0]                     rsp_duty_override,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tac_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                     csr_data
);
   import tac_pkg::*;

   tac_cfg_type  cfg_ff;
   logic         push;
   tac_tick_type push_data;
   logic         q_full;
   logic         pop;
   tac_tick_type pop_data;
   logic         q_empty;

   // Register file. Writes to an unknown index are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timer_period <= RESET_TIMER_PERIOD;
         cfg_ff.min_edge_gap <= RESET_MIN_EDGE_GAP;
         cfg_ff.stall_rpm    <= RESET_STALL_RPM;
         cfg_ff.idle_duty    <= RESET_IDLE_DUTY;
         cfg_ff.rpm_scale    <= RESET_RPM_SCALE;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TIMER_PERIOD: cfg_ff.timer_period <= csr_data;
            CSR_MIN_EDGE_GAP: cfg_ff.min_edge_gap <= csr_data;
            CSR_STALL_RPM:    cfg_ff.stall_rpm    <= csr_data;
            CSR_IDLE_DUTY:    cfg_ff.idle_duty    <= csr_data;
            CSR_RPM_SCALE:    cfg_ff.rpm_scale    <= csr_data[7:0];
            default:          cfg_ff              <= cfg_ff;
         endcase
      end
   end

   // The front counts pulses and snapshots the count on each tick.
   tac_front u_front (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_edge_time      (req_edge_time),
      .req_pin_level      (req_pin_level),
      .req_requested_duty (req_requested_duty),
      .push               (push),
      .push_data          (push_data),
      .q_full             (q_full)
   );

   // The queue lets the front keep taking ticks while the receiver stalls, until it fills.
   tac_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   // The back turns each tick into rpm, runs the stall decision and averages.
   tac_back #(
      .AVG_DEPTH    (AVG_DEPTH),
      .RETRY_PHASES (RETRY_PHASES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .pop               (pop),
      .pop_data          (pop_data),
      .q_empty           (q_empty),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_rpm           (rsp_rpm),
      .rsp_average_rpm   (rsp_average_rpm),
      .rsp_stalled       (rsp_stalled),
      .rsp_duty_override (rsp_duty_override)
   );

endmodule
